[design/apbl_pkg.sv]
// Shared types and constants for the aging peer blocklist.
`default_nettype none
package apbl_pkg;

  localparam int unsigned APBL_ENTRIES = 32;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned CNT_W  = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [CNT_W-1:0]  CNT_ONE       = CNT_W'(1);
  localparam logic [TIME_W-1:0] EXPIRY_RESET  = TIME_W'(300000000);

  localparam logic OP_NOTE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Lookup result rippled from cell to cell.
  typedef struct packed {
    logic             hit;
    logic             live;
    logic [CNT_W-1:0] count;
  } apbl_hit_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic eval;
    logic upd;
    logic ins;
  } apbl_ctl_t;

endpackage : apbl_pkg
`default_nettype wire

[design/apbl_cell.sv]
// One table entry of the blocklist with its lookup and free-slot chain links.
`default_nettype none
module apbl_cell
  import apbl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire apbl_ctl_t         ctl,
  input  wire logic [ADDR_W-1:0] req_addr,
  input  wire logic [PORT_W-1:0] req_port,
  input  wire logic [TIME_W-1:0] req_time,
  input  wire logic [TIME_W-1:0] expiry,
  input  wire apbl_hit_t         hit_in,
  output apbl_hit_t              hit_out,
  input  wire logic              free_in,
  output logic                   free_out
);

  logic              valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;
  logic [TIME_W-1:0] last_r;
  logic [CNT_W-1:0]  count_r;
  logic              hit_r;
  logic              exp_r;

  logic              hit_nxt;
  logic              exp_nxt;
  logic [TIME_W:0]   diff;
  logic [CNT_W-1:0]  cnt_inc;
  logic              avail;
  logic              claim;

  assign diff    = {1'b0, req_time} - {1'b0, last_r};
  assign hit_nxt = valid_r && (addr_r == req_addr) && (port_r == req_port);
  // Backwards time reads as live.
  assign exp_nxt = valid_r && !diff[TIME_W] && (diff[TIME_W-1:0] >= expiry);
  assign cnt_inc = (count_r == CNT_MAX) ? CNT_MAX : count_r + CNT_ONE;

  assign hit_out.hit   = hit_in.hit | hit_r;
  assign hit_out.live  = hit_in.live | (hit_r & ~exp_r);
  assign hit_out.count = hit_in.count | (hit_r ? cnt_inc : '0);

  assign avail    = !valid_r || exp_r;
  assign claim    = avail && !free_in;
  assign free_out = free_in | avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      exp_r   <= 1'b0;
    end else begin
      if (ctl.eval) begin
        hit_r <= hit_nxt;
        exp_r <= exp_nxt;
      end
      if (ctl.ins) begin
        if (claim) begin
          valid_r <= 1'b1;
        end else if (exp_r) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && hit_r) begin
      last_r  <= req_time;
      count_r <= cnt_inc;
    end else if (ctl.ins && claim) begin
      addr_r  <= req_addr;
      port_r  <= req_port;
      last_r  <= req_time;
      count_r <= CNT_ONE;
    end
  end

endmodule : apbl_cell
`default_nettype wire

[design/aging_peer_blocklist.sv]
// Top level of the aging peer blocklist: request register, sequencer, cell row, result register.
// A result is loaded into the result register on the commit that follows the evaluate pass of its
//   input transaction. The next item is taken on the commit edge of the current one, once the
//   evaluate and commit passes over the cell row are through; it is not taken before then.
// A commit waits while an earlier result is still held in the output register.
// Reset (rst_n, synchronous, active low) empties the table and restores the expiry time.
`default_nettype none
module aging_peer_blocklist
  import apbl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = APBL_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_operation,
  input  wire logic [ADDR_W-1:0] in_peer_address,
  input  wire logic [PORT_W-1:0] in_peer_port,
  input  wire logic [TIME_W-1:0] in_current_time_us,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_listed,
  output logic                   out_accepted,
  output logic [CNT_W-1:0]       out_offence_total,
  output logic                   out_bad_request
);

  // One-hot sequencer: evaluate every cell, then commit through the chains.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] expiry_r;

  // Held request of the item in flight.
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;
  logic [TIME_W-1:0] time_r;

  // Result register.
  logic              out_valid_r;
  logic              listed_r;
  logic              accepted_r;
  logic [CNT_W-1:0]  total_r;
  logic              bad_r;

  logic              listed_nxt;
  logic              accepted_nxt;
  logic [CNT_W-1:0]  total_nxt;
  logic              bad_nxt;

  logic              in_take;
  logic              out_free;
  logic              commit;
  logic              addr_zero;
  logic              is_note;
  apbl_ctl_t         ctl;
  apbl_hit_t         hit_all;
  logic              free_all;

  apbl_hit_t         hit_ch  [TABLE_ENTRIES+1];
  logic              free_ch [TABLE_ENTRIES+1];

  // Hold the expiry time; writes must come only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else if (cfg_wr_en) begin
      expiry_r <= cfg_wr_data;
    end
  end

  // Commit only when the result register can take the answer.
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_COMMIT) && out_free;
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_nxt = in_take ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request; the commit edge still sees the old one.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_operation;
      addr_r <= in_peer_address;
      port_r <= in_peer_port;
      time_r <= in_current_time_us;
    end
  end

  assign addr_zero = (addr_r == '0);
  assign is_note   = (op_r == OP_NOTE);

  // Refresh the hit entry, or age out expired entries and insert at the first free cell.
  assign ctl.eval = (state_r == ST_EVAL);
  assign ctl.upd  = commit && is_note && !addr_zero && hit_all.hit;
  assign ctl.ins  = commit && is_note && !addr_zero && !hit_all.hit;

  assign hit_ch[0]  = '0;
  assign free_ch[0] = 1'b0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    apbl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .req_addr (addr_r),
      .req_port (port_r),
      .req_time (time_r),
      .expiry   (expiry_r),
      .hit_in   (hit_ch[g]),
      .hit_out  (hit_ch[g+1]),
      .free_in  (free_ch[g]),
      .free_out (free_ch[g+1])
    );
  end

  assign hit_all  = hit_ch[TABLE_ENTRIES];
  assign free_all = free_ch[TABLE_ENTRIES];

  // Load the answer on commit; drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Form the answer: query, empty address, refresh, insert, or drop when full.
  always_comb begin
    listed_nxt   = 1'b0;
    accepted_nxt = 1'b0;
    total_nxt    = '0;
    bad_nxt      = 1'b0;
    if (!is_note) begin
      listed_nxt = !addr_zero && hit_all.live;
    end else if (addr_zero) begin
      bad_nxt = 1'b1;
    end else if (hit_all.hit) begin
      listed_nxt   = 1'b1;
      accepted_nxt = 1'b1;
      total_nxt    = hit_all.count;
    end else if (free_all) begin
      accepted_nxt = 1'b1;
      total_nxt    = CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      listed_r   <= listed_nxt;
      accepted_r <= accepted_nxt;
      total_r    <= total_nxt;
      bad_r      <= bad_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_listed        = listed_r;
  assign out_accepted      = accepted_r;
  assign out_offence_total = total_r;
  assign out_bad_request   = bad_r;

`ifndef SYNTH
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_COMMIT))
    else $error("result appeared without a commit");

  a_take_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EVAL)
    else $error("accepted transaction did not start evaluation");

  a_bad_is_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> !accepted_r && !listed_r && (total_r == '0))
    else $error("bad request result carries other flags");

  a_no_double_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.upd && ctl.ins))
    else $error("refresh and insert in the same cycle");
`endif

endmodule : aging_peer_blocklist
`default_nettype wire
